@@ rtl/sclt_pkg.sv @@
// shared constants, tables and types for the scan code to lcd terminal
package sclt_pkg;

    localparam int PAGES_DEF      = 8;
    localparam int PAGE_CHARS_DEF = 32;
    localparam int LINE_CHARS     = 16;

    localparam logic [7:0] SC_BREAK  = 8'hF0;
    localparam logic [7:0] SC_LSHIFT = 8'h12;
    localparam logic [7:0] SC_RSHIFT = 8'h59;
    localparam logic [7:0] SC_CAPS   = 8'h58;
    localparam logic [7:0] SC_BKSP   = 8'h66;
    localparam logic [7:0] SC_ENTER  = 8'h5A;
    localparam logic [7:0] SC_F9     = 8'h01;

    localparam logic [7:0] INS_BACK      = 8'h10;
    localparam logic [7:0] INS_LINE1     = 8'h80;
    localparam logic [7:0] INS_LINE2     = 8'hC0;
    localparam logic [7:0] INS_CLEAR     = 8'h01;
    localparam logic [7:0] INS_LINE1_END = 8'h8F;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    // byte classes found by the decoder
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_SHIFT = 3'd1;
    localparam logic [2:0] K_CAPS  = 3'd2;
    localparam logic [2:0] K_BKSP  = 3'd3;
    localparam logic [2:0] K_ENTER = 3'd4;
    localparam logic [2:0] K_CLEAR = 3'd5;
    localparam logic [2:0] K_FKEY  = 3'd6;
    localparam logic [2:0] K_PRINT = 3'd7;

    // datapath commands
    typedef struct packed {
        logic       ld_byte;    // capture the request byte and decode it
        logic       set_break;
        logic       clr_break;
        logic       set_shift;
        logic       clr_shift;
        logic       tog_caps;
        logic       pos_dec;
        logic       pos_inc;
        logic       pos_line2;
        logic       pos_zero;
        logic       page_adv;
        logic       page_sel;
        logic       store_char;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;      // read page text at recall index
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       brk;
        logic       pos_zero;   // position is zero
        logic       pos_line1e; // position is LINE_CHARS-1
        logic       brk_code;   // captured byte is the break prefix
        logic       pos_full;   // position at page end
        logic       pos_last;   // position at page end - 1
        logic       idx_line;   // recall index at LINE_CHARS-1
        logic       idx_last;   // recall index at last character
        logic [7:0] ch;         // mapped character
        logic [7:0] rd_data;    // page text read data
    } t_stat;

    // key code to table index, 63 for unknown
    function automatic logic [5:0] key_index(input logic [7:0] b);
        case (b)
            8'h0E: key_index = 6'd0;   8'h16: key_index = 6'd1;
            8'h1E: key_index = 6'd2;   8'h26: key_index = 6'd3;
            8'h25: key_index = 6'd4;   8'h2E: key_index = 6'd5;
            8'h36: key_index = 6'd6;   8'h3D: key_index = 6'd7;
            8'h3E: key_index = 6'd8;   8'h46: key_index = 6'd9;
            8'h45: key_index = 6'd10;  8'h4E: key_index = 6'd11;
            8'h55: key_index = 6'd12;  8'h15: key_index = 6'd13;
            8'h1D: key_index = 6'd14;  8'h24: key_index = 6'd15;
            8'h2D: key_index = 6'd16;  8'h2C: key_index = 6'd17;
            8'h35: key_index = 6'd18;  8'h3C: key_index = 6'd19;
            8'h43: key_index = 6'd20;  8'h44: key_index = 6'd21;
            8'h4D: key_index = 6'd22;  8'h54: key_index = 6'd23;
            8'h5B: key_index = 6'd24;  8'h1C: key_index = 6'd25;
            8'h1B: key_index = 6'd26;  8'h23: key_index = 6'd27;
            8'h2B: key_index = 6'd28;  8'h34: key_index = 6'd29;
            8'h33: key_index = 6'd30;  8'h3B: key_index = 6'd31;
            8'h42: key_index = 6'd32;  8'h4B: key_index = 6'd33;
            8'h4C: key_index = 6'd34;  8'h52: key_index = 6'd35;
            8'h5D: key_index = 6'd36;  8'h61: key_index = 6'd37;
            8'h1A: key_index = 6'd38;  8'h22: key_index = 6'd39;
            8'h21: key_index = 6'd40;  8'h2A: key_index = 6'd41;
            8'h32: key_index = 6'd42;  8'h31: key_index = 6'd43;
            8'h3A: key_index = 6'd44;  8'h41: key_index = 6'd45;
            8'h49: key_index = 6'd46;  8'h4A: key_index = 6'd47;
            8'h29: key_index = 6'd48;
            default: key_index = 6'd63;
        endcase
    endfunction

    // function key to page number, 15 for none
    function automatic logic [3:0] fkey_index(input logic [7:0] b);
        case (b)
            8'h05: fkey_index = 4'd0;
            8'h06: fkey_index = 4'd1;
            8'h04: fkey_index = 4'd2;
            8'h0C: fkey_index = 4'd3;
            8'h03: fkey_index = 4'd4;
            8'h0B: fkey_index = 4'd5;
            8'h83: fkey_index = 4'd6;
            8'h0A: fkey_index = 4'd7;
            default: fkey_index = 4'd15;
        endcase
    endfunction

    // shift and caps swap case on letters, shift alone picks symbols
    function automatic logic [7:0] map_char(input logic [5:0] idx,
                                            input logic shift, input logic caps);
        logic [7:0] lo;
        logic [7:0] sh;
        logic       letter;
        lo = 8'h20;
        sh = 8'h20;
        letter = 1'b0;
        case (idx)
            6'd0:  begin lo = "|";   sh = 8'hDF; end
            6'd1:  begin lo = "1";   sh = "!"; end
            6'd2:  begin lo = "2";   sh = "\""; end
            6'd3:  begin lo = "3";   sh = "#"; end
            6'd4:  begin lo = "4";   sh = "$"; end
            6'd5:  begin lo = "5";   sh = "%"; end
            6'd6:  begin lo = "6";   sh = "&"; end
            6'd7:  begin lo = "7";   sh = "/"; end
            6'd8:  begin lo = "8";   sh = "("; end
            6'd9:  begin lo = "9";   sh = ")"; end
            6'd10: begin lo = "0";   sh = "="; end
            6'd11: begin lo = "'";   sh = "?"; end
            6'd12: begin lo = 8'hBF; sh = 8'hA1; end
            6'd13: begin lo = "q"; letter = 1'b1; end
            6'd14: begin lo = "w"; letter = 1'b1; end
            6'd15: begin lo = "e"; letter = 1'b1; end
            6'd16: begin lo = "r"; letter = 1'b1; end
            6'd17: begin lo = "t"; letter = 1'b1; end
            6'd18: begin lo = "y"; letter = 1'b1; end
            6'd19: begin lo = "u"; letter = 1'b1; end
            6'd20: begin lo = "i"; letter = 1'b1; end
            6'd21: begin lo = "o"; letter = 1'b1; end
            6'd22: begin lo = "p"; letter = 1'b1; end
            6'd23: begin lo = 8'hB4; sh = 8'hA8; end
            6'd24: begin lo = "+";   sh = "*"; end
            6'd25: begin lo = "a"; letter = 1'b1; end
            6'd26: begin lo = "s"; letter = 1'b1; end
            6'd27: begin lo = "d"; letter = 1'b1; end
            6'd28: begin lo = "f"; letter = 1'b1; end
            6'd29: begin lo = "g"; letter = 1'b1; end
            6'd30: begin lo = "h"; letter = 1'b1; end
            6'd31: begin lo = "j"; letter = 1'b1; end
            6'd32: begin lo = "k"; letter = 1'b1; end
            6'd33: begin lo = "l"; letter = 1'b1; end
            6'd34: begin lo = 8'hF1; letter = 1'b1; end
            6'd35: begin lo = "{";   sh = "["; end
            6'd36: begin lo = "}";   sh = "]"; end
            6'd37: begin lo = "<";   sh = ">"; end
            6'd38: begin lo = "z"; letter = 1'b1; end
            6'd39: begin lo = "x"; letter = 1'b1; end
            6'd40: begin lo = "c"; letter = 1'b1; end
            6'd41: begin lo = "v"; letter = 1'b1; end
            6'd42: begin lo = "b"; letter = 1'b1; end
            6'd43: begin lo = "n"; letter = 1'b1; end
            6'd44: begin lo = "m"; letter = 1'b1; end
            6'd45: begin lo = ",";   sh = ";"; end
            6'd46: begin lo = ".";   sh = ":"; end
            6'd47: begin lo = "-";   sh = "_"; end
            6'd48: begin lo = " ";   sh = " "; end
            default: begin lo = 8'h20; sh = 8'h20; end
        endcase
        if (letter) begin
            map_char = (shift ^ caps) ? (lo & 8'hDF) : lo;
        end else begin
            map_char = shift ? sh : lo;
        end
    endfunction

endpackage

@@ rtl/sclt_ram.sv @@
// generic simple dual port ram with registered read
module sclt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

@@ rtl/sclt_datapath.sv @@
// keyboard state, screen position, page stores and recall read path
module sclt_datapath #(
    parameter int PAGES      = sclt_pkg::PAGES_DEF,
    parameter int PAGE_CHARS = sclt_pkg::PAGE_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_scan_byte,
    input  sclt_pkg::t_cmd i_cmd,
    output sclt_pkg::t_stat o_stat
);
    import sclt_pkg::*;

    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW = $clog2(PAGE_CHARS + 1);
    localparam int IW = $clog2(PAGE_CHARS);
    localparam int AW = $clog2(PAGES * PAGE_CHARS);
    localparam int VD = PAGES * PAGE_CHARS;

    logic          r_brk, r_shift, r_caps;
    logic [CW-1:0] r_pos;
    logic [PW-1:0] r_page;
    logic [PW-1:0] r_fpage;
    logic [2:0]    r_kind;
    logic [5:0]    r_kidx;
    logic          r_brk_code;
    logic [CW-1:0] r_fill [PAGES];
    logic [IW-1:0] r_idx;
    logic          r_rd_valid;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    ram_q;
    logic [CW-1:0] cur_fill;
    logic          do_store;
    logic [3:0]    fk;
    logic [2:0]    kind;
    logic [PW-1:0] fpage;

    // byte classification
    always_comb begin
        fk = fkey_index(i_scan_byte);
        if (i_scan_byte == SC_LSHIFT || i_scan_byte == SC_RSHIFT) begin
            kind = K_SHIFT;
        end else if (i_scan_byte == SC_CAPS) begin
            kind = K_CAPS;
        end else if (i_scan_byte == SC_BKSP) begin
            kind = K_BKSP;
        end else if (i_scan_byte == SC_ENTER) begin
            kind = K_ENTER;
        end else if (i_scan_byte == SC_F9) begin
            kind = K_CLEAR;
        end else if (fk != 4'd15) begin
            kind = K_FKEY;
        end else if (key_index(i_scan_byte) != 6'd63) begin
            kind = K_PRINT;
        end else begin
            kind = K_NONE;
        end
    end

    // function key to page, wrapped by the page count
    always_comb begin
        fpage = '0;
        for (int k = 0; k < 8; k++) begin
            if (fk == 4'(k)) fpage = PW'(k % PAGES);
        end
    end

    // byte capture; break prefix falls to none and is flagged apart
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_byte) begin
            r_kind     <= (i_scan_byte == SC_BREAK) ? K_NONE : kind;
            r_brk_code <= (i_scan_byte == SC_BREAK);
            r_kidx     <= key_index(i_scan_byte);
            r_fpage    <= fpage;
        end
    end

    assign cur_fill = r_fill[r_page];
    assign do_store = i_cmd.store_char && (cur_fill < CW'(PAGE_CHARS));
    assign wr_addr  = AW'(r_page) * AW'(PAGE_CHARS) + AW'(cur_fill[IW-1:0]);
    assign rd_addr  = AW'(r_page) * AW'(PAGE_CHARS) + AW'(r_idx);

    // keyboard, screen and page state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk   <= 1'b0;
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_pos   <= '0;
            r_page  <= '0;
            r_idx   <= '0;
            r_rd_valid <= 1'b0;
            for (int p = 0; p < PAGES; p++) begin
                r_fill[p] <= '0;
            end
        end else begin
            if (i_cmd.set_break) r_brk <= 1'b1;
            if (i_cmd.clr_break) r_brk <= 1'b0;
            if (i_cmd.set_shift) r_shift <= 1'b1;
            if (i_cmd.clr_shift) r_shift <= 1'b0;
            if (i_cmd.tog_caps)  r_caps <= ~r_caps;
            if (i_cmd.pos_dec)   r_pos <= r_pos - 1'b1;
            if (i_cmd.pos_inc)   r_pos <= r_pos + 1'b1;
            if (i_cmd.pos_line2) r_pos <= CW'(LINE_CHARS);
            if (i_cmd.pos_zero)  r_pos <= '0;
            if (i_cmd.page_sel)  r_page <= r_fpage;
            if (i_cmd.page_adv) begin
                r_page <= (32'(r_page) == PAGES - 1) ? '0 : r_page + 1'b1;
            end
            if (do_store) begin
                r_fill[r_page] <= cur_fill + 1'b1;
            end
            if (i_cmd.idx_clr) r_idx <= '0;
            if (i_cmd.idx_inc) r_idx <= r_idx + 1'b1;
            // entries below the fill count have been written
            if (i_cmd.rd_en) r_rd_valid <= (CW'(r_idx) < cur_fill);
        end
    end

    sclt_ram #(.WIDTH(8), .DEPTH(VD)) u_text (
        .i_clk   (i_clk),
        .i_we    (do_store),
        .i_waddr (wr_addr),
        .i_wdata (o_stat.ch),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // status to the controller
    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.brk        = r_brk;
        o_stat.pos_zero   = (r_pos == '0);
        o_stat.pos_line1e = (r_pos == CW'(LINE_CHARS - 1));
        o_stat.brk_code   = r_brk_code;
        o_stat.pos_full   = (r_pos >= CW'(PAGE_CHARS));
        o_stat.pos_last   = (r_pos == CW'(PAGE_CHARS - 1));
        o_stat.idx_line   = (r_idx == IW'(LINE_CHARS - 1));
        o_stat.idx_last   = (r_idx == IW'(PAGE_CHARS - 1));
        o_stat.ch         = map_char(r_kidx, r_shift, r_caps);
        o_stat.rd_data    = r_rd_valid ? ram_q : CH_SPACE;
    end
endmodule

@@ rtl/sclt_ctrl.sv @@
// sequencer that turns one scan byte into its lcd writes
module sclt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_stall,
    output logic            o_valid,
    output logic            o_is_instruction,
    output logic [7:0]      o_lcd_byte,
    output logic            o_last_write,
    input  sclt_pkg::t_stat i_stat,
    output sclt_pkg::t_cmd  o_cmd
);
    import sclt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_BK1   = 4'd2;
    localparam logic [3:0] S_BK2   = 4'd3;
    localparam logic [3:0] S_BK3   = 4'd4;
    localparam logic [3:0] S_BK4   = 4'd5;
    localparam logic [3:0] S_BK5   = 4'd6;
    localparam logic [3:0] S_BK6   = 4'd7;
    localparam logic [3:0] S_CLR2  = 4'd8;
    localparam logic [3:0] S_RCL   = 4'd9;
    localparam logic [3:0] S_RCHR  = 4'd10;
    localparam logic [3:0] S_RL2   = 4'd11;
    localparam logic [3:0] S_REND  = 4'd12;
    localparam logic [3:0] S_PR2   = 4'd13;
    localparam logic [3:0] S_RWAIT = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       r_ins, n_ins;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_pend, n_pend;  // pending instr after a printable char
    logic [7:0] r_pbyte, n_pbyte;
    logic       out_free;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_is_instruction = r_ins;
    assign o_lcd_byte = r_byte;
    assign o_last_write = r_last;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        n_ins    = r_ins;
        n_byte   = r_byte;
        n_last   = r_last;
        n_pend   = r_pend;
        n_pbyte  = r_pbyte;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_byte = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.brk) begin
                    o_cmd.clr_break = 1'b1;
                    if (i_stat.kind == K_SHIFT) o_cmd.clr_shift = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    case (i_stat.kind)
                        K_NONE: begin
                            // the break prefix arrives here as none
                            if (i_stat.brk_code) o_cmd.set_break = 1'b1;
                            n_state = S_IDLE;
                        end
                        K_SHIFT: begin
                            o_cmd.set_shift = 1'b1;
                            n_state = S_IDLE;
                        end
                        K_CAPS: begin
                            o_cmd.tog_caps = 1'b1;
                            n_state = S_IDLE;
                        end
                        K_BKSP: begin
                            if (!i_stat.pos_zero) n_state = S_BK1;
                            else if (i_stat.pos_line1e) n_state = S_BK4;
                            else n_state = S_IDLE;
                        end
                        K_ENTER: begin
                            if (out_free) begin
                                n_ovalid = 1'b1; n_ins = 1'b1;
                                n_byte = INS_LINE2; n_last = 1'b1;
                                o_cmd.pos_line2 = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                        K_CLEAR: begin
                            if (out_free) begin
                                n_ovalid = 1'b1; n_ins = 1'b1;
                                n_byte = INS_CLEAR; n_last = 1'b0;
                                n_state = S_CLR2;
                            end
                        end
                        K_FKEY: begin
                            if (out_free) begin
                                n_ovalid = 1'b1; n_ins = 1'b1;
                                n_byte = INS_CLEAR; n_last = 1'b0;
                                o_cmd.page_sel = 1'b1;
                                o_cmd.idx_clr = 1'b1;
                                n_state = S_RCL;
                            end
                        end
                        K_PRINT: begin
                            if (i_stat.pos_full) begin
                                n_state = S_IDLE;
                            end else if (out_free) begin
                                n_ovalid = 1'b1; n_ins = 1'b0;
                                n_byte = i_stat.ch;
                                o_cmd.store_char = 1'b1;
                                o_cmd.pos_inc = 1'b1;
                                if (i_stat.pos_last) begin
                                    n_pend = 1'b1; n_pbyte = INS_CLEAR;
                                    o_cmd.page_adv = 1'b1;
                                end else if (i_stat.pos_line1e) begin
                                    n_pend = 1'b1; n_pbyte = INS_LINE2;
                                end else begin
                                    n_pend = 1'b0;
                                end
                                n_last = !n_pend;
                                n_state = n_pend ? S_PR2 : S_IDLE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PR2: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = r_pbyte; n_last = 1'b1;
                    if (r_pbyte == INS_CLEAR) o_cmd.pos_zero = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BK1: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_BACK; n_last = 1'b0;
                    n_state = S_BK2;
                end
            end
            S_BK2: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b0; n_byte = CH_SPACE; n_last = 1'b0;
                    o_cmd.pos_dec = 1'b1;
                    n_state = S_BK3;
                end
            end
            S_BK3: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_BACK;
                    n_last = !i_stat.pos_line1e;
                    n_state = i_stat.pos_line1e ? S_BK4 : S_IDLE;
                end
            end
            S_BK4: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_LINE1_END; n_last = 1'b0;
                    n_state = S_BK5;
                end
            end
            S_BK5: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b0; n_byte = CH_SPACE; n_last = 1'b0;
                    n_state = S_BK6;
                end
            end
            S_BK6: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_BACK; n_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLR2: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_LINE1; n_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RCL: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_LINE1; n_last = 1'b0;
                    o_cmd.rd_en = 1'b1;
                    n_state = S_RWAIT;
                end
            end
            S_RWAIT: begin
                // read the character at the recall index
                o_cmd.rd_en = 1'b1;
                n_state = S_RCHR;
            end
            S_RCHR: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b0; n_byte = i_stat.rd_data; n_last = 1'b0;
                    if (i_stat.idx_last) begin
                        n_state = S_REND;
                    end else if (i_stat.idx_line) begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_RL2;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_RWAIT;
                    end
                end
            end
            S_RL2: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_LINE2; n_last = 1'b0;
                    o_cmd.rd_en = 1'b1;
                    n_state = S_RWAIT;
                end
            end
            S_REND: begin
                if (out_free) begin
                    n_ovalid = 1'b1; n_ins = 1'b1; n_byte = INS_LINE1; n_last = 1'b1;
                    o_cmd.pos_zero = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins   <= n_ins;
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_pbyte <= n_pbyte;
    end
endmodule

@@ rtl/scan_code_to_lcd_terminal.sv @@
// top level: ps/2 set-2 scan bytes in, hd44780 writes out
//
// input channel i_valid / o_stall carries one scan byte per request;
// output channel o_valid / i_stall carries one lcd write per request,
// flagged instruction or data, with o_last_write on the final write of
// the scan byte. a byte is taken only when the block is idle.
// the first write is registered from the decode state, or from a
// backspace state for a backspace. a page recall reads each character
// of the page from the text ram, then outputs it as a write. the output
// register holds a write while i_stall is high and the sequencer waits
// on it. reset clears keyboard state, screen position, current page and
// fill counts; a recalled character at or past its page's fill count
// reads as a space, so every page reads as spaces right after reset.
module scan_code_to_lcd_terminal #(
    parameter int PAGES      = sclt_pkg::PAGES_DEF,
    parameter int PAGE_CHARS = sclt_pkg::PAGE_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_scan_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_instruction,
    output logic [7:0] o_lcd_byte,
    output logic       o_last_write
);
    import sclt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sclt_datapath #(.PAGES(PAGES), .PAGE_CHARS(PAGE_CHARS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scan_byte (i_scan_byte),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    sclt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_is_instruction (o_is_instruction),
        .o_lcd_byte       (o_lcd_byte),
        .o_last_write     (o_last_write),
        .i_stat           (stat),
        .o_cmd            (cmd)
    );

    // a held write stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lcd_byte) && $stable(o_last_write))
        else $error("output changed under stall");

    // no new request while a write that is not the last is still out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_write |-> o_stall)
        else $error("request taken mid sequence");

    // position never moves in both directions at once
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.pos_inc && cmd.pos_dec))
        else $error("position conflict");
endmodule

@@ tb/scan_code_to_lcd_terminal_tb.sv @@
// self-checking testbench for the scan code to lcd terminal
module scan_code_to_lcd_terminal_tb;
    import sclt_pkg::*;

    localparam int NPAGES    = 8;
    localparam int NCHARS    = 32;
    localparam int LIMIT_CYC = 5000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_scan_byte;
    logic       o_valid;
    logic       i_stall;
    logic       o_is_instruction;
    logic [7:0] o_lcd_byte;
    logic       o_last_write;

    typedef struct packed {
        logic       instr;
        logic [7:0] data;
        logic       last;
    } t_lcd_write;

    // printable key codes in table order
    localparam logic [7:0] KEY_CODES [49] = '{
        8'h0E,8'h16,8'h1E,8'h26,8'h25,8'h2E,8'h36,8'h3D,8'h3E,8'h46,8'h45,8'h4E,8'h55,
        8'h15,8'h1D,8'h24,8'h2D,8'h2C,8'h35,8'h3C,8'h43,8'h44,8'h4D,8'h54,8'h5B,
        8'h1C,8'h1B,8'h23,8'h2B,8'h34,8'h33,8'h3B,8'h42,8'h4B,8'h4C,8'h52,8'h5D,
        8'h61,8'h1A,8'h22,8'h21,8'h2A,8'h32,8'h31,8'h3A,8'h41,8'h49,8'h4A,8'h29};
    localparam logic [7:0] FKEY_CODES [8] = '{
        8'h05,8'h06,8'h04,8'h0C,8'h03,8'h0B,8'h83,8'h0A};

    // layout tables: lower, caps, shift, shift with caps
    localparam logic [7:0] LAY_LOWER [49] = '{
        "|","1","2","3","4","5","6","7","8","9","0","'",8'hBF,
        "q","w","e","r","t","y","u","i","o","p",8'hB4,"+",
        "a","s","d","f","g","h","j","k","l",8'hF1,"{","}",
        "<","z","x","c","v","b","n","m",",",".","-"," "};
    localparam logic [7:0] LAY_CAPS [49] = '{
        "|","1","2","3","4","5","6","7","8","9","0","'",8'hBF,
        "Q","W","E","R","T","Y","U","I","O","P",8'hB4,"+",
        "A","S","D","F","G","H","J","K","L",8'hD1,"{","}",
        "<","Z","X","C","V","B","N","M",",",".","-"," "};
    localparam logic [7:0] LAY_SHIFT [49] = '{
        8'hDF,"!","\"","#","$","%","&","/","(",")","=","?",8'hA1,
        "Q","W","E","R","T","Y","U","I","O","P",8'hA8,"*",
        "A","S","D","F","G","H","J","K","L",8'hD1,"[","]",
        ">","Z","X","C","V","B","N","M",";",":","_"," "};
    localparam logic [7:0] LAY_SHCAPS [49] = '{
        8'hDF,"!","\"","#","$","%","&","/","(",")","=","?",8'hA1,
        "q","w","e","r","t","y","u","i","o","p",8'hA8,"*",
        "a","s","d","f","g","h","j","k","l",8'hF1,"[","]",
        ">","z","x","c","v","b","n","m",";",":","_"," "};

    // predicted terminal state
    logic       kb_break;
    logic       kb_shift;
    logic       kb_caps;
    int         scr_pos;
    int         cur_page;
    int         fill [NPAGES];
    logic [7:0] text [NPAGES*NCHARS];

    t_lcd_write pending_writes [$];
    t_lcd_write burst [$];
    int         errors;
    longint     cycles = 0;

    scan_code_to_lcd_terminal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_scan_byte(i_scan_byte), .o_valid(o_valid), .i_stall(i_stall),
        .o_is_instruction(o_is_instruction), .o_lcd_byte(o_lcd_byte),
        .o_last_write(o_last_write)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // output stall, with gap-free stretches
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if ($urandom_range(0, 3) != 0) begin
                i_stall <= 1'b1;
                repeat (short_or_long_gap() + 1) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // compare each lcd write with the oldest prediction
    always @(posedge i_clk) begin
        t_lcd_write want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write instr=%0b byte=%h last=%0b", $time,
                         o_is_instruction, o_lcd_byte, o_last_write);
                errors++;
            end else begin
                want = pending_writes.pop_front();
                if (o_is_instruction !== want.instr) begin
                    $display("%0t: is_instruction expected %0b actual %0b", $time,
                             want.instr, o_is_instruction);
                    errors++;
                end
                if (o_lcd_byte !== want.data) begin
                    $display("%0t: lcd_byte expected %h actual %h", $time,
                             want.data, o_lcd_byte);
                    errors++;
                end
                if (o_last_write !== want.last) begin
                    $display("%0t: last_write expected %0b actual %0b", $time,
                             want.last, o_last_write);
                    errors++;
                end
            end
        end
    end

    function automatic void add_write(logic instr, logic [7:0] data);
        t_lcd_write w;
        w.instr = instr;
        w.data  = data;
        w.last  = 1'b0;
        burst.push_back(w);
    endfunction

    function automatic int key_slot(logic [7:0] b);
        for (int k = 0; k < 49; k++) if (KEY_CODES[k] == b) return k;
        return -1;
    endfunction

    function automatic int fkey_slot(logic [7:0] b);
        for (int k = 0; k < 8; k++) if (FKEY_CODES[k] == b) return k;
        return -1;
    endfunction

    // terminal behavior for one scan byte, appends its writes
    function automatic void predict_terminal(logic [7:0] b);
        int         k;
        int         f;
        logic [7:0] ch;
        burst.delete();
        f = fkey_slot(b);
        k = key_slot(b);
        if (kb_break) begin
            kb_break = 1'b0;
            if (b == SC_LSHIFT || b == SC_RSHIFT) kb_shift = 1'b0;
        end else if (b == SC_BREAK) begin
            kb_break = 1'b1;
        end else if (b == SC_LSHIFT || b == SC_RSHIFT) begin
            kb_shift = 1'b1;
        end else if (b == SC_CAPS) begin
            kb_caps = !kb_caps;
        end else if (b == SC_BKSP) begin
            if (scr_pos > 0) begin
                add_write(1'b1, INS_BACK);
                add_write(1'b0, CH_SPACE);
                add_write(1'b1, INS_BACK);
                scr_pos--;
            end
            if (scr_pos == LINE_CHARS - 1) begin
                add_write(1'b1, INS_LINE1_END);
                add_write(1'b0, CH_SPACE);
                add_write(1'b1, INS_BACK);
            end
        end else if (b == SC_ENTER) begin
            add_write(1'b1, INS_LINE2);
            scr_pos = LINE_CHARS;
        end else if (b == SC_F9) begin
            add_write(1'b1, INS_CLEAR);
            add_write(1'b1, INS_LINE1);
        end else if (f >= 0) begin
            cur_page = f % NPAGES;
            add_write(1'b1, INS_CLEAR);
            add_write(1'b1, INS_LINE1);
            for (int i = 0; i < NCHARS; i++) begin
                add_write(1'b0, text[cur_page*NCHARS + i]);
                if (i + 1 == LINE_CHARS) add_write(1'b1, INS_LINE2);
            end
            add_write(1'b1, INS_LINE1);
            scr_pos = 0;
        end else if (k >= 0 && scr_pos < NCHARS) begin
            if (kb_caps && kb_shift) ch = LAY_SHCAPS[k];
            else if (kb_caps)        ch = LAY_CAPS[k];
            else if (kb_shift)       ch = LAY_SHIFT[k];
            else                     ch = LAY_LOWER[k];
            add_write(1'b0, ch);
            if (fill[cur_page] < NCHARS) begin
                text[cur_page*NCHARS + fill[cur_page]] = ch;
                fill[cur_page]++;
            end
            scr_pos++;
            if (scr_pos == LINE_CHARS) add_write(1'b1, INS_LINE2);
            if (scr_pos == NCHARS) begin
                add_write(1'b1, INS_CLEAR);
                scr_pos = 0;
                cur_page = (cur_page + 1) % NPAGES;
            end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[n]) pending_writes.push_back(burst[n]);
    endfunction

    // drive one scan byte request and wait for acceptance
    task automatic send_scan(logic [7:0] b, bit gaps = 1'b1);
        // valid was dropped at the last edge, so let it be seen low before raising it
        @(posedge i_clk);
        if (gaps) begin
            repeat (short_or_long_gap()) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_scan_byte <= b;
        do @(posedge i_clk); while (o_stall);
        predict_terminal(b);
        i_valid     <= 1'b0;
        i_scan_byte <= $urandom_range(0, 255);
    endtask

    task automatic wait_drained();
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    // n random printable keys
    task automatic type_chars(int n);
        for (int i = 0; i < n; i++) send_scan(KEY_CODES[$urandom_range(0, 48)]);
    endtask

    // all four layouts, shift make and break on both shift keys
    task automatic test_layouts();
        send_scan(KEY_CODES[0]);
        send_scan(KEY_CODES[48]);
        send_scan(SC_LSHIFT);
        send_scan(KEY_CODES[0]);
        send_scan(KEY_CODES[13]);
        send_scan(SC_CAPS);
        send_scan(KEY_CODES[34]);
        send_scan(SC_BREAK);
        send_scan(SC_LSHIFT);
        send_scan(KEY_CODES[34]);
        send_scan(SC_RSHIFT);
        send_scan(KEY_CODES[12]);
        send_scan(SC_BREAK);
        send_scan(SC_RSHIFT);
        send_scan(SC_CAPS);
        send_scan(SC_BREAK);
        send_scan(KEY_CODES[5]);
        send_scan(8'hFF);
        send_scan(8'h00);
    endtask

    // line break, backspace across the line, recall, clear
    task automatic test_screen_edges();
        send_scan(SC_BKSP);
        send_scan(SC_ENTER);
        send_scan(SC_BKSP);
        send_scan(SC_BKSP);
        type_chars(17);
        send_scan(SC_F9);
        send_scan(FKEY_CODES[0]);
        send_scan(SC_BKSP);
        send_scan(FKEY_CODES[6]);
        send_scan(FKEY_CODES[7]);
    endtask

    // fill a page store past its end, then pause until drained
    task automatic test_full_store();
        send_scan(FKEY_CODES[1]);
        type_chars(36);
        send_scan(FKEY_CODES[1]);
        send_scan(FKEY_CODES[2]);
        wait_drained();
        repeat (80) @(posedge i_clk);
    endtask

    // mostly keyboard sequences, some noise
    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      send_scan(KEY_CODES[$urandom_range(0, 48)]);
            else if (r < 62) send_scan(SC_BKSP);
            else if (r < 66) send_scan(SC_ENTER);
            else if (r < 71) send_scan(FKEY_CODES[$urandom_range(0, 7)]);
            else if (r < 73) send_scan(SC_F9);
            else if (r < 78) send_scan($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT);
            else if (r < 82) send_scan(SC_CAPS);
            else if (r < 90) begin
                send_scan(SC_BREAK);
                send_scan($urandom_range(0, 1) ? SC_LSHIFT : $urandom_range(0, 255));
            end else if (r < 95) begin
                send_scan(KEY_CODES[$urandom_range(0, 48)], 1'b0);
            end else begin
                send_scan($urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_scan_byte = 8'h00;
        errors      = 0;
        kb_break    = 1'b0;
        kb_shift    = 1'b0;
        kb_caps     = 1'b0;
        scr_pos     = 0;
        cur_page    = 0;
        foreach (fill[p]) fill[p] = 0;
        foreach (text[p]) text[p] = CH_SPACE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_layouts();
        test_screen_edges();
        test_full_store();
        test_random(230);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
